>>> rtl/core/glbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glbw_pkg
// Types, register indexes, constants and LED pattern functions shared by the
// gas level bar with warm-up.
// ----------------------------------------------------------------------------
package glbw_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_WARMUP_TICKS    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DROP_MARGIN     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SHORTENED_TICKS = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MEASURE_PERIOD  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ALARM_LEVEL     = 3'd4;

    // Register reset values
    localparam logic [7:0]  RST_WARMUP_TICKS    = 8'd150;
    localparam logic [9:0]  RST_DROP_MARGIN     = 10'd100;
    localparam logic [7:0]  RST_SHORTENED_TICKS = 8'd10;
    localparam logic [4:0]  RST_MEASURE_PERIOD  = 5'd10;
    localparam logic [15:0] RST_ALARM_LEVEL     = 16'd3000;

    // Chase pattern wraps at this phase
    localparam logic [4:0] CHASE_WRAP = 5'd10;
    localparam logic [4:0] PHASE_MAX  = 5'd31;

    // ppm band edges
    localparam logic [15:0] GREEN_HI   = 16'd900;
    localparam logic [15:0] GREEN2_LO  = 16'd750;
    localparam logic [15:0] GREEN2_HI  = 16'd1100;
    localparam logic [15:0] YELLOW_LO  = 16'd900;
    localparam logic [15:0] YELLOW_HI  = 16'd1900;
    localparam logic [15:0] YELLOW2_LO = 16'd1500;
    localparam logic [15:0] YELLOW2_HI = 16'd2200;
    localparam logic [15:0] RED_LO     = 16'd2000;
    localparam logic [15:0] RED_HI     = 16'd2800;
    localparam logic [15:0] RED2_LO    = 16'd2500;

    typedef struct packed {
        logic [9:0]  sensor_sample;
        logic [15:0] co2_ppm;
    } t_in;

    typedef struct packed {
        logic [5:0] led_bits;
        logic       buzzer_on;
        logic       warming_up;
        logic       reading_taken;
    } t_out;

    typedef struct packed {
        logic [7:0]  warmup_ticks;
        logic [9:0]  drop_margin;
        logic [7:0]  shortened_ticks;
        logic [4:0]  measure_period;
        logic [15:0] alarm_level;
    } t_cfg;

    typedef struct packed {
        logic       in_warmup;
        logic [7:0] warmup_left;
        logic [9:0] peak_sample;
        logic [4:0] tick_phase;
        logic       force_measure;
        logic       alarm_armed;
        logic       toggle_level;
        logic [5:0] led_latch;
    } t_state;

    function automatic logic [5:0] chase_leds(input logic [4:0] ph);
        logic [5:0] leds;
        case (ph)
            5'd1:    leds = 6'h20;
            5'd2:    leds = 6'h30;
            5'd3:    leds = 6'h18;
            5'd4:    leds = 6'h0C;
            5'd5:    leds = 6'h06;
            5'd6:    leds = 6'h03;
            5'd7:    leds = 6'h01;
            default: leds = 6'h00;
        endcase
        return leds;
    endfunction

    function automatic logic [5:0] band_leds(input logic [15:0] p);
        logic [5:0] b;
        b[0] = (p < GREEN_HI);
        b[1] = (p > GREEN2_LO)  && (p < GREEN2_HI);
        b[2] = (p > YELLOW_LO)  && (p < YELLOW_HI);
        b[3] = (p > YELLOW2_LO) && (p < YELLOW2_HI);
        b[4] = (p > RED_LO)     && (p < RED_HI);
        b[5] = (p > RED2_LO);
        return b;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/glbw_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glbw_step
// Next-state and result logic for one tick: warm-up chase and countdown,
// then periodic measurement, band display and buzzer toggle.
// ----------------------------------------------------------------------------
module glbw_step (
    input  wire glbw_pkg::t_state i_state,
    input  wire glbw_pkg::t_cfg   i_cfg,
    input  wire glbw_pkg::t_in    i_data,
    output glbw_pkg::t_state      o_state,
    output glbw_pkg::t_out        o_result
);

    logic [10:0] sample_plus_margin;
    logic [4:0]  chase_phase;
    logic [7:0]  left_cut;
    logic        measure;
    logic [4:0]  phase_meas;
    logic        armed_now;

    always_comb begin
        sample_plus_margin = {1'b0, i_data.sensor_sample} + {1'b0, i_cfg.drop_margin};
        chase_phase = (i_state.tick_phase >= glbw_pkg::CHASE_WRAP) ? 5'd0 : i_state.tick_phase;
        measure     = i_state.force_measure || (i_state.tick_phase >= i_cfg.measure_period);
        phase_meas  = measure ? 5'd0 : i_state.tick_phase;
        armed_now   = measure ? (i_data.co2_ppm > i_cfg.alarm_level) : i_state.alarm_armed;

        // shorten the countdown when the sample falls well below the peak
        left_cut = i_state.warmup_left;
        if ((i_data.sensor_sample <= i_state.peak_sample)
                && (sample_plus_margin < {1'b0, i_state.peak_sample})
                && (i_state.warmup_left > i_cfg.shortened_ticks)) begin
            left_cut = i_cfg.shortened_ticks;
        end

        o_state  = i_state;
        o_result = '0;

        if (i_state.in_warmup) begin
            if (i_state.warmup_left == 8'd0) begin
                o_state.in_warmup     = 1'b0;
                o_state.force_measure = 1'b1;
            end else begin
                if (i_data.sensor_sample > i_state.peak_sample) begin
                    o_state.peak_sample = i_data.sensor_sample;
                end
                o_state.led_latch   = glbw_pkg::chase_leds(i_state.tick_phase);
                o_state.warmup_left = (left_cut != 8'd0) ? left_cut - 8'd1 : 8'd0;
                o_state.tick_phase  = chase_phase + 5'd1;
            end
        end else begin
            if (measure) begin
                o_state.force_measure = 1'b0;
                o_state.led_latch     = glbw_pkg::band_leds(i_data.co2_ppm);
                o_state.alarm_armed   = armed_now;
                o_result.reading_taken = 1'b1;
            end
            if (armed_now) begin
                o_state.toggle_level = ~i_state.toggle_level;
                o_result.buzzer_on   = ~i_state.toggle_level;
            end
            o_state.tick_phase = (phase_meas < glbw_pkg::PHASE_MAX) ? phase_meas + 5'd1
                                                                    : phase_meas;
        end

        o_result.led_bits   = o_state.led_latch;
        o_result.warming_up = o_state.in_warmup;
    end

endmodule
`default_nettype wire

>>> rtl/core/gas_level_bar_with_warmup_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gas_level_bar_with_warmup_top
// Gas level LED bar with sensor warm-up, periodic measurement and buzzer alarm.
// ----------------------------------------------------------------------------
// Each input transaction is one tick and yields exactly one result
// transaction. A tick is processed in the cycle it is accepted and its result
// is registered; one tick per clock is sustained while results are taken and a
// two-entry output stage (output register plus skid register) keeps the input
// side open while a result waits. Configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data; a warmup_ticks write with no tick
// accepted reloads the countdown in warm-up. Unknown indexes are ignored.
module gas_level_bar_with_warmup_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire glbw_pkg::t_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output glbw_pkg::t_out                      o_out_data,
    input  wire                                 i_cfg_we,
    input  wire [glbw_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  wire [glbw_pkg::CfgDataW-1:0]        i_cfg_data
);

    glbw_pkg::t_cfg   r_cfg;
    glbw_pkg::t_state r_state;
    glbw_pkg::t_state n_state;
    glbw_pkg::t_out   n_result;
    glbw_pkg::t_out   r_out;
    glbw_pkg::t_out   r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             in_fire;
    logic             out_fire;

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    glbw_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_data   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup_ticks    <= glbw_pkg::RST_WARMUP_TICKS;
            r_cfg.drop_margin     <= glbw_pkg::RST_DROP_MARGIN;
            r_cfg.shortened_ticks <= glbw_pkg::RST_SHORTENED_TICKS;
            r_cfg.measure_period  <= glbw_pkg::RST_MEASURE_PERIOD;
            r_cfg.alarm_level     <= glbw_pkg::RST_ALARM_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                glbw_pkg::REG_WARMUP_TICKS:    r_cfg.warmup_ticks    <= i_cfg_data[7:0];
                glbw_pkg::REG_DROP_MARGIN:     r_cfg.drop_margin     <= i_cfg_data[9:0];
                glbw_pkg::REG_SHORTENED_TICKS: r_cfg.shortened_ticks <= i_cfg_data[7:0];
                glbw_pkg::REG_MEASURE_PERIOD:  r_cfg.measure_period  <= i_cfg_data[4:0];
                glbw_pkg::REG_ALARM_LEVEL:     r_cfg.alarm_level     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.in_warmup     <= 1'b1;
            r_state.warmup_left   <= glbw_pkg::RST_WARMUP_TICKS;
            r_state.peak_sample   <= '0;
            r_state.tick_phase    <= '0;
            r_state.force_measure <= 1'b0;
            r_state.alarm_armed   <= 1'b0;
            r_state.toggle_level  <= 1'b0;
            r_state.led_latch     <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end else if (i_cfg_we && (i_cfg_index == glbw_pkg::REG_WARMUP_TICKS)
                     && r_state.in_warmup) begin
            // reload the countdown while still warming up
            r_state.warmup_left <= i_cfg_data[7:0];
        end
    end

    // output register and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_fire) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire;
                end
            end else if (in_fire) begin
                // hold the new transaction behind the stalled one
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_fire) begin
            r_skid <= n_result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a transaction while output register is empty");

    a_accept_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted tick left no result in output register");

    a_quiet_in_warmup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.warming_up) |-> (!r_out.buzzer_on && !r_out.reading_taken))
        else $error("buzzer or measurement during warm-up");

    a_buzz_needs_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_result.buzzer_on) |=> r_state.alarm_armed)
        else $error("buzzer driven without an armed alarm");

endmodule
`default_nettype wire

>>> tb/gas_bar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_bar_checker
// Follows the configuration writes and the tick transactions, works out the
// LED bar, buzzer and status flags that each tick should produce, and compares
// them in order with the result transactions that the block hands out.
// ----------------------------------------------------------------------------
module gas_bar_checker (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_ready,
    input  wire glbw_pkg::t_in           i_in_data,
    input  wire                          i_out_valid,
    input  wire                          i_out_ready,
    input  wire glbw_pkg::t_out          i_out_data,
    input  wire                          i_cfg_we,
    input  wire [glbw_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire [glbw_pkg::CfgDataW-1:0] i_cfg_data,
    output int                           o_mismatches,
    output int                           o_pending
);
    import glbw_pkg::*;

    localparam logic [7:0]  WARMUP_AT_RESET  = 8'd150;
    localparam logic [9:0]  MARGIN_AT_RESET  = 10'd100;
    localparam logic [7:0]  SHORTEN_AT_RESET = 8'd10;
    localparam logic [4:0]  PERIOD_AT_RESET  = 5'd10;
    localparam logic [15:0] ALARM_AT_RESET   = 16'd3000;
    localparam logic [4:0]  CHASE_LAST_PHASE = 5'd10;
    localparam logic [4:0]  PHASE_CEILING    = 5'd31;
    localparam int          REPORT_LIMIT     = 10;

    // settings as last written
    logic [7:0]  warmup_setting;
    logic [9:0]  margin_setting;
    logic [7:0]  shorten_setting;
    logic [4:0]  period_setting;
    logic [15:0] alarm_setting;

    // tracked block state
    logic       warming;
    logic [7:0] ticks_left;
    logic [9:0] peak;
    logic [4:0] phase;
    logic       measure_due;
    logic       alarm_on;
    logic       buzz_level;
    logic [5:0] bar_leds;

    t_out pending_bars[$];
    int   mismatches;

    function automatic logic [5:0] chase_pattern(input logic [4:0] ph);
        logic [5:0] pattern;
        case (ph)
            5'd1:    pattern = 6'b100000;
            5'd2:    pattern = 6'b110000;
            5'd3:    pattern = 6'b011000;
            5'd4:    pattern = 6'b001100;
            5'd5:    pattern = 6'b000110;
            5'd6:    pattern = 6'b000011;
            5'd7:    pattern = 6'b000001;
            default: pattern = 6'b000000;
        endcase
        return pattern;
    endfunction

    // bands overlap, so several LEDs may light at once
    function automatic logic [5:0] ppm_bands(input logic [15:0] ppm);
        int level;
        level = int'(ppm);
        return {level > 2500,
                level > 2000 && level < 2800,
                level > 1500 && level < 2200,
                level > 900 && level < 1900,
                level > 750 && level < 1100,
                level < 900};
    endfunction

    function automatic t_out advance_tick(input t_in tick);
        t_out res;
        res = '0;
        if (warming) begin
            if (ticks_left == 8'd0) begin
                // closing warm-up tick: leave the chase pattern on show
                warming = 1'b0;
                measure_due = 1'b1;
            end else begin
                if (tick.sensor_sample > peak) begin
                    peak = tick.sensor_sample;
                end else if (int'(tick.sensor_sample) + int'(margin_setting) < int'(peak) &&
                             ticks_left > shorten_setting) begin
                    ticks_left = shorten_setting;
                end
                bar_leds = chase_pattern(phase);
                if (phase >= CHASE_LAST_PHASE) phase = '0;
                if (ticks_left != 8'd0) ticks_left = ticks_left - 8'd1;
                phase = phase + 5'd1;
            end
        end else begin
            if (measure_due || phase >= period_setting) begin
                measure_due = 1'b0;
                phase = '0;
                bar_leds = ppm_bands(tick.co2_ppm);
                alarm_on = tick.co2_ppm > alarm_setting;
                res.reading_taken = 1'b1;
            end
            if (alarm_on) begin
                buzz_level = ~buzz_level;
                res.buzzer_on = buzz_level;
            end
            if (phase < PHASE_CEILING) phase = phase + 5'd1;
        end
        res.led_bits = bar_leds;
        res.warming_up = warming;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            warmup_setting  = WARMUP_AT_RESET;
            margin_setting  = MARGIN_AT_RESET;
            shorten_setting = SHORTEN_AT_RESET;
            period_setting  = PERIOD_AT_RESET;
            alarm_setting   = ALARM_AT_RESET;
            warming     = 1'b1;
            ticks_left  = WARMUP_AT_RESET;
            peak        = '0;
            phase       = '0;
            measure_due = 1'b0;
            alarm_on    = 1'b0;
            buzz_level  = 1'b0;
            bar_leds    = '0;
            pending_bars.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WARMUP_TICKS: begin
                        warmup_setting = i_cfg_data[7:0];
                        if (warming) ticks_left = i_cfg_data[7:0];
                    end
                    REG_DROP_MARGIN:     margin_setting  = i_cfg_data[9:0];
                    REG_SHORTENED_TICKS: shorten_setting = i_cfg_data[7:0];
                    REG_MEASURE_PERIOD:  period_setting  = i_cfg_data[4:0];
                    REG_ALARM_LEVEL:     alarm_setting   = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) pending_bars.push_back(advance_tick(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pending_bars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected bar transaction: leds %02h buzz %0b warm %0b taken %0b",
                                 got.led_bits, got.buzzer_on, got.warming_up, got.reading_taken);
                end else begin
                    want = pending_bars.pop_front();
                    if (got.led_bits !== want.led_bits || got.buzzer_on !== want.buzzer_on ||
                        got.warming_up !== want.warming_up ||
                        got.reading_taken !== want.reading_taken) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("bar mismatch at %0t: expected leds %02h buzz %0b warm %0b %s%0b, %s%02h buzz %0b warm %0b taken %0b",
                                     $realtime, want.led_bits, want.buzzer_on, want.warming_up,
                                     "taken ", want.reading_taken, "got leds ",
                                     got.led_bits, got.buzzer_on, got.warming_up,
                                     got.reading_taken);
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending <= pending_bars.size();
    end

endmodule

>>> tb/gas_level_bar_with_warmup_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_level_bar_with_warmup_top_test
// Drives the gas level bar through one warm-up (peak tracking, chase pattern,
// countdown reloads and cuts) and then through many measurement settings with
// random ticks, random gaps on both channels and one long output stall. The
// checker beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module gas_level_bar_with_warmup_top_test;
    import glbw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 16;
    localparam int WARM_ITEMS   = 120;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASES       = 10;
    localparam logic [CfgIdxW-1:0] REG_SPARE_LO = REG_ALARM_LEVEL + 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tick_valid = 1'b0;
    logic                tick_ready;
    t_in                 tick_data = '0;
    logic                bar_valid;
    logic                bar_ready = 1'b0;
    t_out                bar_data;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_request = 1'b0;
    logic hold_served = 1'b0;
    int hold_left = 0;
    int cycles = 0;
    int mismatches;
    int pending;

    gas_level_bar_with_warmup_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_ready  (tick_ready),
        .i_in_data   (tick_data),
        .o_out_valid (bar_valid),
        .i_out_ready (bar_ready),
        .o_out_data  (bar_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gas_bar_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (tick_valid),
        .i_in_ready   (tick_ready),
        .i_in_data    (tick_data),
        .i_out_valid  (bar_valid),
        .i_out_ready  (bar_ready),
        .i_out_data   (bar_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    // receiver: random back-pressure, plus one long hold when asked
    always @(posedge clk) begin
        if (!rst_n) begin
            bar_ready <= 1'b0;
        end else if (hold_left != 0) begin
            bar_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_served) begin
            bar_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_served <= 1'b1;
        end else begin
            bar_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // drop valid and wait until every result transaction has come back
    task automatic settle();
        tick_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic send_tick(input logic [9:0] sample, input logic [15:0] ppm);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_data <= '{sensor_sample: sample, co2_ppm: ppm};
        do @(posedge clk); while (!tick_ready);
    endtask

    function automatic logic [9:0] warm_sample();
        case ($urandom_range(0, 3))
            0, 1:    return 10'($urandom_range(0, 1023));
            2:       return 10'($urandom_range(1000, 1023));
            default: return $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        endcase
    endfunction

    // lean on the band edges, where the LED decisions flip
    function automatic logic [15:0] random_ppm();
        int band_edges[10] = '{750, 900, 1100, 1500, 1900, 2000, 2200, 2500, 2800, 3000};
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return 16'(band_edges[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1);
            2:       return 16'($urandom_range(0, 3500));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // upper bits beyond each register's width are noise and must be dropped
    task automatic random_settings(input int p);
        logic [4:0]  period;
        logic [15:0] alarm;
        if (p == 1) begin
            period = 5'd1;
            alarm = 16'h0000;
        end else if (p == 2) begin
            period = 5'd31;
            alarm = 16'hFFFF;
        end else begin
            period = $urandom_range(0, 1) ? 5'($urandom_range(1, 4)) : 5'($urandom_range(1, 31));
            alarm = random_ppm();
        end
        write_reg(REG_WARMUP_TICKS,
                  16'($urandom_range(1, 255)) | (16'($urandom) & 16'hFF00));
        write_reg(REG_DROP_MARGIN,
                  16'($urandom_range(0, 1023)) | (16'($urandom) & 16'hFC00));
        write_reg(REG_SHORTENED_TICKS,
                  16'($urandom_range(0, 255)) | (16'($urandom) & 16'hFF00));
        write_reg(REG_MEASURE_PERIOD, 16'(period) | (16'($urandom) & 16'hFFE0));
        write_reg(REG_ALARM_LEVEL, alarm);
        if ($urandom_range(0, 2) == 0)
            write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        set_idling(19, 70);

        // warm-up: extremes, no cut possible with the widest margin
        settle();
        write_reg(REG_WARMUP_TICKS, 16'd255);
        write_reg(REG_DROP_MARGIN, 16'd1023);
        write_reg(REG_SHORTENED_TICKS, 16'd255);
        write_reg(REG_MEASURE_PERIOD, 16'd31);
        write_reg(REG_ALARM_LEVEL, 16'hFFFF);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0000);
        cfg_we <= 1'b0;
        send_tick(10'd0, 16'd0);
        send_tick(10'd1023, 16'hFFFF);
        send_tick(10'd0, 16'hFFFF);
        send_tick(10'd512, 16'd1000);

        // reload the countdown mid warm-up, then cut it on a one-count drop
        settle();
        write_reg(REG_WARMUP_TICKS, 16'd30);
        write_reg(REG_DROP_MARGIN, 16'd0);
        write_reg(REG_SHORTENED_TICKS, 16'd12);
        cfg_we <= 1'b0;
        send_tick(10'd1023, 16'd0);
        send_tick(10'd1022, 16'd0);
        send_tick(10'd1023, 16'd900);
        send_tick(10'd0, 16'hFFFF);
        send_tick(10'd1023, 16'd1100);
        send_tick(10'd512, 16'd2500);
        send_tick(10'd1, 16'd2800);
        send_tick(10'd1023, 16'd3000);

        // long random warm-up: the cut value is high enough that warm-up does not end
        settle();
        write_reg(REG_WARMUP_TICKS, 16'd255);
        write_reg(REG_DROP_MARGIN, 16'($urandom_range(0, 300)));
        write_reg(REG_SHORTENED_TICKS, 16'($urandom_range(130, 255)));
        cfg_we <= 1'b0;
        repeat (WARM_ITEMS) send_tick(warm_sample(), random_ppm());

        // cut the countdown to zero, end warm-up, take the forced reading
        settle();
        write_reg(REG_SHORTENED_TICKS, 16'd0);
        write_reg(REG_DROP_MARGIN, 16'd100);
        cfg_we <= 1'b0;
        send_tick(10'd1023, 16'd0);
        send_tick(10'd0, 16'd0);
        send_tick(10'd0, 16'd0);
        send_tick(10'd0, 16'd2501);

        // period of zero measures on every tick; alarm level extremes
        settle();
        write_reg(REG_MEASURE_PERIOD, 16'd0);
        write_reg(REG_ALARM_LEVEL, 16'd0);
        cfg_we <= 1'b0;
        send_tick(10'd0, 16'd0);
        send_tick(10'd0, 16'd1);
        send_tick(10'd1023, 16'hFFFF);
        send_tick(10'd512, 16'd899);
        settle();
        write_reg(REG_ALARM_LEVEL, 16'hFFFF);
        cfg_we <= 1'b0;
        send_tick(10'd0, 16'hFFFF);

        for (int p = 1; p <= PHASES; p++) begin
            settle();
            if (p == 4) set_idling(70, 19);
            if (p == 8) set_idling(0, 0);
            random_settings(p);
            // hold the output off while ticks keep coming, so the block fills
            if (p == 8) hold_request <= 1'b1;
            repeat (PHASE_ITEMS) send_tick(10'($urandom_range(0, 1023)), random_ppm());
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
